FILE: rtl/core/owbm_pkg.sv
package owbm_pkg;

  localparam int unsigned CFG_W          = 10;
  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned BYTE_GAP_TICKS = 240;
  localparam int unsigned BITS_PER_BYTE  = 8;

  typedef logic [CFG_W-1:0]                count_t;
  typedef logic [$clog2(NUM_REGS)-1:0]     cfg_idx_t;
  typedef logic [NUM_REGS-1:0][CFG_W-1:0]  cfg_t;

  localparam cfg_idx_t REG_RESET_LOW     = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PRESENCE_WAIT = cfg_idx_t'(1);
  localparam cfg_idx_t REG_SHORT_LOW     = cfg_idx_t'(2);
  localparam cfg_idx_t REG_LONG_LOW      = cfg_idx_t'(3);
  localparam cfg_idx_t REG_ONE_RECOVERY  = cfg_idx_t'(4);
  localparam cfg_idx_t REG_ZERO_RECOVERY = cfg_idx_t'(5);
  localparam cfg_idx_t REG_READ_SAMPLE   = cfg_idx_t'(6);
  localparam cfg_idx_t REG_READ_TAIL     = cfg_idx_t'(7);

  localparam cfg_t CFG_RESET = {
    count_t'(40), count_t'(10), count_t'(10), count_t'(60),
    count_t'(70), count_t'(10), count_t'(90), count_t'(500)
  };

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_GAP       = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_SLOT_REL  = 3'd5,
    PH_READ_TAIL = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

endpackage

FILE: rtl/core/owbm_cfg_regs.sv
module owbm_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  owbm_pkg::cfg_idx_t wr_index,
  input  owbm_pkg::count_t  wr_data,
  output owbm_pkg::cfg_t    cfg
);
  import owbm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      cfg[wr_index] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/owbm_fsm.sv
module owbm_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  owbm_pkg::in_item_t  item,
  input  owbm_pkg::cfg_t      cfg,
  output owbm_pkg::out_item_t result
);
  import owbm_pkg::*;

  localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);
  localparam count_t     GAP_TICKS = count_t'(BYTE_GAP_TICKS);

  phase_t     phase, phase_next;
  op_t        operation, operation_next;
  count_t     tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       presence_flag, presence_flag_next;
  logic [7:0] last_read, last_read_next;

  count_t tick_inc;
  count_t dur;
  logic   ends;
  logic   cur_bit;
  logic   done;
  logic   rejected;

  assign tick_inc = tick_count + count_t'(1);
  assign cur_bit  = shift_byte[bit_index];

  always_comb begin
    unique case (phase)
      PH_RST_LOW:   dur = cfg[REG_RESET_LOW];
      PH_RST_WAIT:  dur = cfg[REG_PRESENCE_WAIT];
      PH_GAP:       dur = GAP_TICKS;
      PH_SLOT_LOW:  dur = (operation == OP_WRITE && !cur_bit) ? cfg[REG_LONG_LOW]
                                                              : cfg[REG_SHORT_LOW];
      PH_SLOT_REL: begin
        if (operation == OP_READ) begin
          dur = cfg[REG_READ_SAMPLE];
        end else begin
          dur = cur_bit ? cfg[REG_ONE_RECOVERY] : cfg[REG_ZERO_RECOVERY];
        end
      end
      PH_READ_TAIL: dur = cfg[REG_READ_TAIL];
      default:      dur = '0;
    endcase
  end

  assign ends = (tick_inc >= dur);

  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    done               = 1'b0;
    rejected           = 1'b0;

    if (step_en) begin
      if (action_t'(item.action) != ACT_TICK) begin
        if (phase != PH_IDLE) begin
          rejected = 1'b1;
        end else if (action_t'(item.action) == ACT_RESET) begin
          operation_next  = OP_RESET;
          phase_next      = PH_RST_LOW;
          tick_count_next = '0;
        end else begin
          operation_next  = (action_t'(item.action) == ACT_WRITE) ? OP_WRITE : OP_READ;
          shift_byte_next = (action_t'(item.action) == ACT_WRITE) ? item.data_byte : 8'd0;
          bit_index_next  = '0;
          tick_count_next = '0;
          phase_next      = (BYTE_GAP_TICKS == 0) ? PH_SLOT_LOW : PH_GAP;
        end
      end else if (phase != PH_IDLE) begin
        tick_count_next = ends ? count_t'(0) : tick_inc;
        unique case (phase)
          PH_RST_LOW: begin
            if (ends) phase_next = PH_RST_WAIT;
          end
          PH_RST_WAIT: begin
            if (ends) begin
              presence_flag_next = !item.line_in;
              phase_next         = PH_IDLE;
              operation_next     = OP_NONE;
              done               = 1'b1;
            end
          end
          PH_GAP: begin
            if (ends) phase_next = PH_SLOT_LOW;
          end
          PH_SLOT_LOW: begin
            if (ends) phase_next = PH_SLOT_REL;
          end
          PH_SLOT_REL, PH_READ_TAIL: begin
            if (ends) begin
              if (phase == PH_SLOT_REL && operation == OP_READ) begin
                if (item.line_in) shift_byte_next[bit_index] = 1'b1;
                phase_next = PH_READ_TAIL;
              end else if (bit_index >= LAST_BIT) begin
                if (operation == OP_READ) last_read_next = shift_byte;
                phase_next     = PH_IDLE;
                operation_next = OP_NONE;
                bit_index_next = '0;
                done           = 1'b1;
              end else begin
                bit_index_next = bit_index + 3'd1;
                phase_next     = PH_SLOT_LOW;
              end
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            operation_next  = OP_NONE;
            tick_count_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= OP_NONE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      last_read     <= '0;
    end else begin
      phase         <= phase_next;
      operation     <= operation_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      last_read     <= last_read_next;
    end
  end

  always_comb begin
    result.line_low  = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
    result.busy_res  = (phase_next != PH_IDLE);
    result.done_res  = done;
    result.presence  = presence_flag_next;
    result.read_data = last_read_next;
    result.rejected  = rejected;
  end

endmodule

FILE: rtl/core/one_wire_bus_master.sv
// 1-Wire bus master. Each input item is either a one-microsecond tick carrying the sampled
// bus level or a command (reset-presence, write byte, read byte), and each item produces
// exactly one result item with the bus drive, busy, done, presence, last read byte and a
// rejected flag for commands that arrive while an operation is running. All slot timing is
// counted in ticks against eight 10-bit timing registers written through the configuration
// port, which is always ready. Items are taken at one per clock cycle while out_ready does not
// stall the result output; an accepted item is held in the input register, stepped through the
// timing state machine, whose result is combinational, and captured in the result register.
module one_wire_bus_master (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  owbm_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output owbm_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  owbm_pkg::cfg_idx_t   cfg_index,
  input  owbm_pkg::count_t     cfg_data
);
  import owbm_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t step_result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  owbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owbm_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  a_low_implies_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.line_low || out_item.busy_res))
    else $error("bus driven low while no operation is in progress");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res && !out_item.rejected)
    else $error("completion reported while still busy or on a rejected command");

  a_reject_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.rejected |-> out_item.busy_res)
    else $error("command rejected while the master was idle");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("a processed item did not reach the result register");

endmodule
